@@ rtl/mvm_pkg.sv @@
// Shared types and constants for the matrix-vector multiply block.
// Used by mvm_cell, matrix_vector_multiply and mvm_checker; depends on nothing.
package mvm_pkg;

  // largest matrix dimension the stores hold
  localparam int MAX_SIZE = 16;
  localparam int IDX_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  // register and field widths
  localparam int SIZE_W   = 5;
  localparam int FIELD_W  = 4;
  localparam int DATA_W   = 32;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int FRAC_W   = 16;
  // product width plus headroom for summing up to MAX_SIZE terms
  localparam int ACC_W    = PROD_W + $clog2(MAX_SIZE) + 1;
  // width that holds both a cell number and a size for comparisons
  localparam int CMP_W    = ((IDX_W > SIZE_W) ? IDX_W : SIZE_W) + 1;

  // largest size actually used
  localparam int SIZE_CAP = (MAX_SIZE < 16) ? MAX_SIZE : 16;

  // apb register map
  localparam int ADDR_W = 3;
  localparam logic REG_SIZE      = 1'b0;
  localparam logic REG_TRANSPOSE = 1'b1;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  // action codes
  localparam logic [1:0] ACT_MAT_WR  = 2'd0;
  localparam logic [1:0] ACT_VEC_WR  = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  // input request
  typedef struct packed {
    logic [1:0]                action;
    logic [FIELD_W-1:0]        row_index;
    logic [FIELD_W-1:0]        col_index;
    logic signed [DATA_W-1:0]  value;
  } in_req_t;

  // output request
  typedef struct packed {
    logic [FIELD_W-1:0]        result_index;
    logic signed [DATA_W-1:0]  result_value;
    logic                      saturated;
    logic                      last;
  } out_res_t;

  // store write broadcast to every cell
  typedef struct packed {
    logic                      mat_en;
    logic                      vec_en;
    logic [FIELD_W-1:0]        row;
    logic [FIELD_W-1:0]        col;
    logic signed [DATA_W-1:0]  value;
  } wr_bus_t;

  // partial sum token handed from cell to cell
  typedef struct packed {
    logic                      valid;
    logic                      last;
    logic [IDX_W-1:0]          idx;
    logic signed [ACC_W-1:0]   sum;
  } chain_tok_t;

endpackage

@@ rtl/mvm_cell.sv @@
// One cell of the dot-product chain: holds vector entry k, matrix column k
// and matrix row k, and adds its product to the passing partial sum.
// Depends on mvm_pkg.
module mvm_cell import mvm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [IDX_W-1:0]  cell_idx_i,
  input  logic [SIZE_W-1:0] size_i,
  input  logic              transpose_i,
  input  wr_bus_t           wr_i,
  input  chain_tok_t        tok_i,
  output chain_tok_t        tok_o
);

  logic signed [DATA_W-1:0] col_mem [MAX_SIZE];
  logic signed [DATA_W-1:0] row_mem [MAX_SIZE];
  logic signed [DATA_W-1:0] vec_q;
  logic signed [DATA_W-1:0] rd_col_q, rd_row_q;
  logic signed [DATA_W-1:0] operand;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  chain_tok_t               s1_q, s2_q, s3_q, s3_d;
  logic                     col_hit, row_hit, active;

  // address decode against this cell's number
  assign col_hit = (CMP_W'(wr_i.col) == CMP_W'(cell_idx_i));
  assign row_hit = (CMP_W'(wr_i.row) == CMP_W'(cell_idx_i));
  assign active  = (CMP_W'(cell_idx_i) < CMP_W'(size_i));

  // column k is indexed by row, row k by column
  always_ff @(posedge clk_i) begin
    if (wr_i.mat_en && col_hit) begin
      col_mem[IDX_W'(wr_i.row)] <= wr_i.value;
    end
    if (wr_i.mat_en && row_hit) begin
      row_mem[IDX_W'(wr_i.col)] <= wr_i.value;
    end
    if (wr_i.vec_en && col_hit) begin
      vec_q <= wr_i.value;
    end
  end

  // stage 1 reads the stores, stage 2 multiplies
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rd_col_q <= col_mem[tok_i.idx];
      rd_row_q <= row_mem[tok_i.idx];
      prod_q   <= prod_d;
    end
  end

  // idle cells beyond the size in use add nothing
  always_comb begin
    operand = transpose_i ? rd_row_q : rd_col_q;
    prod_d  = operand * vec_q;
    if (!active) begin
      prod_d = '0;
    end
  end

  // stage 3 accumulates
  always_comb begin
    s3_d     = s2_q;
    s3_d.sum = s2_q.sum + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  end

  // token pipeline alongside the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else if (adv_i) begin
      s1_q <= tok_i;
      s2_q <= s1_q;
      s3_q <= s3_d;
    end
  end

  assign tok_o = s3_q;

endmodule

@@ rtl/matrix_vector_multiply.sv @@
// Top level of the matrix-vector multiply block: apb registers, request
// sequencer, the chain of mvm_cell instances and saturating output register.
// Depends on mvm_pkg and mvm_cell.

// Write requests (matrix entry, vector entry) are accepted back to back. A
// compute request of active size n is held off from further requests until
// its last result is taken: n tokens enter a chain of MAX_SIZE (16) cells,
// one per cycle while no result is stalled; each cell has three register
// stages (store read, multiply, accumulate), and every token passes through
// all MAX_SIZE cells, so the chain depth sets the latency. A stalled result
// freezes the whole chain. Results are truncated Q16.16 and saturated,
// flagged with saturated, and the final one of a run carries last.
// Register 0 (address 0) is matrix_size, register 1 (address 4) is
// transpose_mode; change them only while the block is idle.
module matrix_vector_multiply import mvm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // apb configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_req_t           in_req_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_res_t          out_res_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [SIZE_W-1:0] size_q;
  logic              transpose_q;
  logic [SIZE_W-1:0] n_act, n_q;
  logic [SIZE_W-1:0] issue_idx_q;
  logic [1:0]        state_q, state_d;
  logic              cfg_wr, in_acc, out_acc, adv, issue_last;
  logic              out_valid_q;
  out_res_t          out_q, res_d;
  wr_bus_t           wr_bus;
  chain_tok_t        tok [MAX_SIZE+1];
  logic [ACC_W-FRAC_W-DATA_W:0] head;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SIZE_RESET;
      transpose_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SIZE:      size_q      <= pwdata[SIZE_W-1:0];
        REG_TRANSPOSE: transpose_q <= pwdata[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SIZE:      prdata = {{(32-SIZE_W){1'b0}}, size_q};
      REG_TRANSPOSE: prdata = {31'b0, transpose_q};
      default:       prdata = '0;
    endcase
  end

  // size in use: zero acts as one, large values clip to the cap
  always_comb begin
    priority if (size_q == '0) begin
      n_act = SIZE_W'(1);
    end else if (CMP_W'(size_q) > CMP_W'(SIZE_CAP)) begin
      n_act = SIZE_W'(SIZE_CAP);
    end else begin
      n_act = size_q;
    end
  end

  // handshakes
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign adv         = !out_valid_q || !out_stall_i;

  // store writes go straight to the cells
  always_comb begin
    wr_bus.mat_en = in_acc && (in_req_i.action == ACT_MAT_WR) &&
                    (CMP_W'(in_req_i.row_index) < CMP_W'(MAX_SIZE)) &&
                    (CMP_W'(in_req_i.col_index) < CMP_W'(MAX_SIZE));
    wr_bus.vec_en = in_acc && (in_req_i.action == ACT_VEC_WR);
    wr_bus.row    = in_req_i.row_index;
    wr_bus.col    = in_req_i.col_index;
    wr_bus.value  = in_req_i.value;
  end

  // sequencer: issue one token per result index, then wait for the last result
  assign issue_last = (issue_idx_q == n_q - SIZE_W'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (in_req_i.action == ACT_COMPUTE)) state_d = S_ISSUE;
      end
      S_ISSUE: begin
        if (adv && issue_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (out_acc && out_q.last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= SIZE_W'(1);
      issue_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE) begin
        n_q         <= n_act;
        issue_idx_q <= '0;
      end else if (state_q == S_ISSUE && adv) begin
        issue_idx_q <= issue_idx_q + SIZE_W'(1);
      end
    end
  end

  // token entering the first cell
  always_comb begin
    tok[0].valid = (state_q == S_ISSUE);
    tok[0].last  = issue_last;
    tok[0].idx   = IDX_W'(issue_idx_q);
    tok[0].sum   = '0;
  end

  // chain of cells
  for (genvar k = 0; k < MAX_SIZE; k++) begin : g_cell
    mvm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .cell_idx_i  (IDX_W'(k)),
      .size_i      (n_q),
      .transpose_i (transpose_q),
      .wr_i        (wr_bus),
      .tok_i       (tok[k]),
      .tok_o       (tok[k+1])
    );
  end

  // truncate to q16.16 and saturate
  assign head = tok[MAX_SIZE].sum[ACC_W-1:FRAC_W+DATA_W-1];

  always_comb begin
    res_d.result_index = FIELD_W'(tok[MAX_SIZE].idx);
    res_d.last         = tok[MAX_SIZE].last;
    if ((&head) || !(|head)) begin
      res_d.saturated    = 1'b0;
      res_d.result_value = tok[MAX_SIZE].sum[FRAC_W+DATA_W-1:FRAC_W];
    end else begin
      res_d.saturated    = 1'b1;
      res_d.result_value = head[ACC_W-FRAC_W-DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                     : {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tok[MAX_SIZE].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && tok[MAX_SIZE].valid) begin
      out_q <= res_d;
    end
  end

endmodule

@@ rtl/mvm_checker.sv @@
// Port-level checks for matrix_vector_multiply, bound to the top level.
// Depends on mvm_pkg and matrix_vector_multiply.
module mvm_port_checks import mvm_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input in_req_t  in_req_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_res_t out_res_o
);

  // a pending result means a compute is still in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result shown while input side is open");

  // a compute request closes the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_req_i.action == ACT_COMPUTE) |=> in_stall_o)
    else $error("input open right after compute request");

  // taking the last result reopens the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_res_o.last) |=> !in_stall_o)
    else $error("input still stalled after last result");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_res_o)))
    else $error("stalled result changed");

endmodule

bind matrix_vector_multiply mvm_port_checks u_mvm_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);

@@ tb/mvm_checker.sv @@
// Result checker for the matrix-vector multiply block: watches the apb port and
// both request channels, predicts each dot product and compares field by field.
// Depends on mvm_pkg.
module mvm_checker import mvm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // apb port, observed
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  // input channel, observed
  input  logic              req_valid_i,
  input  logic              req_stall_i,
  input  in_req_t           req_i,
  // output channel, observed
  input  logic              res_valid_i,
  input  logic              res_stall_i,
  input  out_res_t          res_i,
  // status for the top
  output int                errors_o,
  output int                pending_o,
  output int                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // sum wide enough for sixteen full-range products
  localparam int SUM_W = PROD_W + 8;
  localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] Q_MIN = SUM_W'(-64'sh0000_0000_8000_0000);

  logic [DATA_W-1:0] matrix_entries [MAX_SIZE][MAX_SIZE];
  logic [DATA_W-1:0] vector_entries [MAX_SIZE];
  logic [SIZE_W-1:0] size_q;
  logic              transpose_q;
  out_res_t          product_q [$];
  out_res_t          want;
  int                error_count;
  int                result_count;

  // report a single field that differs
  function automatic void check_field(input string what, input logic [DATA_W-1:0] want_v,
                                      input logic [DATA_W-1:0] got_v);
    if (want_v !== got_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
    end
  endfunction

  // queue one truncated, saturated dot product per row (or column when transposed)
  function automatic void predict_products();
    int unsigned              n;
    logic signed [DATA_W-1:0] m_ent;
    logic signed [DATA_W-1:0] v_ent;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  acc;
    logic signed [SUM_W-1:0]  q;
    out_res_t                 r;
    n = (size_q == '0) ? 1 : ((size_q > SIZE_CAP) ? SIZE_CAP : size_q);
    for (int unsigned i = 0; i < n; i++) begin
      acc = '0;
      for (int unsigned k = 0; k < n; k++) begin
        m_ent = transpose_q ? matrix_entries[k][i] : matrix_entries[i][k];
        v_ent = vector_entries[k];
        prod  = m_ent * v_ent;
        acc   = acc + prod;
      end
      // arithmetic shift rounds toward minus infinity
      q = acc >>> FRAC_W;
      r.result_index = FIELD_W'(i);
      r.last         = (i == n - 1);
      if (q > Q_MAX) begin
        r.result_value = 32'h7FFF_FFFF;
        r.saturated    = 1'b1;
      end else if (q < Q_MIN) begin
        r.result_value = 32'h8000_0000;
        r.saturated    = 1'b1;
      end else begin
        r.result_value = q[DATA_W-1:0];
        r.saturated    = 1'b0;
      end
      product_q.push_back(r);
    end
  endfunction

  // track registers and stores, match results against predictions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q       = SIZE_RESET;
      transpose_q  = 1'b0;
      error_count  = 0;
      result_count = 0;
      product_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      // register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_SIZE) begin
          size_q = pwdata_i[SIZE_W-1:0];
        end else begin
          transpose_q = pwdata_i[0];
        end
      end
      // accepted result
      if (res_valid_i && !res_stall_i) begin
        if (product_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, got index %0d value %h",
                   $time, res_i.result_index, res_i.result_value);
        end else begin
          want = product_q.pop_front();
          check_field("result_index", DATA_W'(want.result_index), DATA_W'(res_i.result_index));
          check_field("result_value", want.result_value, res_i.result_value);
          check_field("saturated", DATA_W'(want.saturated), DATA_W'(res_i.saturated));
          check_field("last", DATA_W'(want.last), DATA_W'(res_i.last));
          result_count++;
        end
      end
      // accepted request
      if (req_valid_i && !req_stall_i) begin
        case (req_i.action)
          ACT_MAT_WR: begin
            matrix_entries[req_i.row_index][req_i.col_index] = req_i.value;
          end
          ACT_VEC_WR: begin
            vector_entries[req_i.col_index] = req_i.value;
          end
          ACT_COMPUTE: begin
            predict_products();
          end
          default: begin
          end
        endcase
      end
      errors_o  <= error_count;
      pending_o <= product_q.size();
      checked_o <= result_count;
    end
  end

endmodule

@@ tb/testbench.sv @@
// Top of the matrix-vector multiply testbench: clock, reset, apb setup and
// request stimulus with idle and stall mixes; checking lives in mvm_checker.
// Depends on mvm_pkg, matrix_vector_multiply and mvm_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mvm_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  // chain depth plus a full run of results plus margin
  localparam int SETTLE_CYCLES = 3 * MAX_SIZE + MAX_SIZE + 16;
  localparam int PHASE_ITEMS   = 55;
  localparam logic [1:0]        ACT_IGNORED = 2'd3;
  localparam logic [DATA_W-1:0] Q_ONE       = 32'h0001_0000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_req_t           in_req_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_res_t          out_res_o;

  int errors;
  int pending;
  int checked;
  int cycles         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int computes_sent  = 0;
  int unsigned       active_n;
  logic [MAX_SIZE-1:0] mat_loaded [MAX_SIZE];
  logic [MAX_SIZE-1:0] vec_loaded;

  matrix_vector_multiply DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  mvm_checker product_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .req_valid_i(in_valid_i),
    .req_stall_i(in_stall_o),
    .req_i      (in_req_i),
    .res_valid_i(out_valid_o),
    .res_stall_i(out_stall_i),
    .res_i      (out_res_o),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // random receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL matrix_vector_multiply");
      $finish;
    end
  end

  // entry values: full range, small, medium and extremes
  function automatic logic [DATA_W-1:0] rand_value();
    logic [16:0] s17;
    logic [20:0] s21;
    logic [25:0] s26;
    s17 = $urandom();
    s21 = $urandom();
    s26 = $urandom();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return {{11{s21[20]}}, s21};
      2: return {{6{s26[25]}}, s26};
      3: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return Q_ONE;
        endcase
      end
      default: return {{15{s17[16]}}, s17};
    endcase
  endfunction

  // present one request and hold it until taken
  task automatic send_req(input in_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
    case (r.action)
      ACT_MAT_WR:  mat_loaded[r.row_index][r.col_index] = 1'b1;
      ACT_VEC_WR:  vec_loaded[r.col_index] = 1'b1;
      ACT_COMPUTE: computes_sent++;
      default: ;
    endcase
  endtask

  task automatic write_matrix(input int r, input int c, input logic [DATA_W-1:0] v);
    in_req_t q;
    q.action    = ACT_MAT_WR;
    q.row_index = FIELD_W'(r);
    q.col_index = FIELD_W'(c);
    q.value     = v;
    send_req(q);
  endtask

  // row field is unused here, so it carries noise
  task automatic write_vector(input int c, input logic [DATA_W-1:0] v);
    in_req_t q;
    q.action    = ACT_VEC_WR;
    q.row_index = FIELD_W'($urandom());
    q.col_index = FIELD_W'(c);
    q.value     = v;
    send_req(q);
  endtask

  task automatic compute();
    in_req_t q;
    q.action    = ACT_COMPUTE;
    q.row_index = FIELD_W'($urandom());
    q.col_index = FIELD_W'($urandom());
    q.value     = $urandom();
    send_req(q);
  endtask

  task automatic send_ignored();
    in_req_t q;
    q.action    = ACT_IGNORED;
    q.row_index = FIELD_W'($urandom());
    q.col_index = FIELD_W'($urandom());
    q.value     = $urandom();
    send_req(q);
  endtask

  // stop sending, wait for all results, then let the chain empty
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write: setup cycle, access cycle, then psel and penable return low
  task automatic cfg_write(input logic reg_sel, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({reg_sel, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [SIZE_W-1:0] size_val, input logic tr);
    drain();
    cfg_write(REG_SIZE, 32'(size_val));
    cfg_write(REG_TRANSPOSE, 32'(tr));
    active_n = (size_val == '0) ? 1 : ((size_val > SIZE_CAP) ? SIZE_CAP : size_val);
  endtask

  // one job: configure, scatter writes with some noise, fill the gaps, compute
  task automatic run_job(input logic [SIZE_W-1:0] size_val, input logic tr);
    int n_writes;
    int pick;
    set_config(size_val, tr);
    n_writes = $urandom_range(0, (active_n <= 4) ? active_n * active_n + active_n + 4 : 24);
    for (int w = 0; w < n_writes; w++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        if ($urandom_range(0, 3) != 0) begin
          write_matrix($urandom_range(0, active_n - 1), $urandom_range(0, active_n - 1),
                       rand_value());
        end else begin
          write_vector($urandom_range(0, active_n - 1), rand_value());
        end
      end else if (pick < 92) begin
        if ($urandom_range(0, 1) != 0) begin
          write_matrix($urandom_range(0, MAX_SIZE - 1), $urandom_range(0, MAX_SIZE - 1),
                       rand_value());
        end else begin
          write_vector($urandom_range(0, MAX_SIZE - 1), rand_value());
        end
      end else begin
        send_ignored();
      end
    end
    // no compute may read an entry never written
    for (int r = 0; r < active_n; r++) begin
      for (int c = 0; c < active_n; c++) begin
        if (!mat_loaded[r][c]) write_matrix(r, c, rand_value());
      end
    end
    for (int c = 0; c < active_n; c++) begin
      if (!vec_loaded[c]) write_vector(c, rand_value());
    end
    compute();
    if ($urandom_range(0, 2) == 0) compute();
  endtask

  // main sequence
  initial begin
    int phase_end;
    for (int r = 0; r < MAX_SIZE; r++) mat_loaded[r] = '0;
    vec_loaded = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // size zero acts as one: saturation both ways and truncation of a tiny negative
    set_config(5'd0, 1'b0);
    write_matrix(0, 0, 32'h7FFF_FFFF);
    write_vector(0, 32'h7FFF_FFFF);
    compute();
    write_matrix(0, 0, 32'h8000_0000);
    write_vector(0, 32'h8000_0000);
    compute();
    write_vector(0, 32'h7FFF_FFFF);
    compute();
    write_matrix(0, 0, 32'h0000_0001);
    write_vector(0, 32'hFFFF_FFFF);
    compute();
    // unknown action and a write beyond the size in use
    send_ignored();
    write_matrix(MAX_SIZE - 1, MAX_SIZE - 1, 32'h1234_5678);

    // small known product in both orientations
    set_config(5'd2, 1'b1);
    write_matrix(0, 0, Q_ONE);
    write_matrix(0, 1, 32'h0002_0000);
    write_matrix(1, 0, 32'h0003_0000);
    write_matrix(1, 1, 32'h0004_0000);
    write_vector(0, Q_ONE);
    write_vector(1, 32'hFFFF_8000);
    compute();
    set_config(5'd2, 1'b0);
    compute();

    // random jobs under four idle and stall mixes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      // oversize register value acts as the full size; later the full size itself
      if (p == 0) run_job(5'd31, 1'b0);
      if (p == 2) run_job(5'd16, 1'b1);
      while (items_sent < phase_end) begin
        run_job(($urandom_range(0, 9) == 0) ? 5'd0 : SIZE_W'($urandom_range(1, 6)),
                1'($urandom_range(0, 1)));
      end
    end

    drain();
    $display("covered %0d requests with %0d products, %0d results checked",
             items_sent, computes_sent, checked);
    $display("sizes zero to full and oversize, both orientations, saturation and idle mixes");
    if (errors == 0) begin
      $display("PASS matrix_vector_multiply");
    end else begin
      $display("FAIL matrix_vector_multiply");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mvm_pkg.sv
rtl/mvm_cell.sv
rtl/matrix_vector_multiply.sv
rtl/mvm_checker.sv
tb/mvm_checker.sv
tb/testbench.sv
